[src/dpdc_pkg.sv]
`timescale 1ns / 1ps

package dpdc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 12;
  localparam int unsigned KindW   = 3;
  localparam int unsigned NibbleW = 4;

  // Framing characters of the remote serial link.
  localparam logic [ByteW-1:0] ChStart = 8'h24;  // '$'
  localparam logic [ByteW-1:0] ChEnd   = 8'h23;  // '#'
  localparam logic [ByteW-1:0] ChAck   = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] ChNak   = 8'h2D;  // '-'

  localparam logic [CountW-1:0] MaxPayloadReset = 12'd4095;

  typedef enum logic [KindW-1:0] {
    KindPayload  = 3'd0,
    KindGood     = 3'd1,
    KindMismatch = 3'd2,
    KindOverflow = 3'd3,
    KindAbort    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data_byte;
    logic [CountW-1:0]  payload_length;
    logic [ByteW-1:0]   computed_sum;
    logic [ByteW-1:0]   received_sum;
  } result_t;

  typedef struct packed {
    logic              bad;
    logic [NibbleW-1:0] nibble;
  } hex_t;

  // Decodes one ASCII hex digit, either case. A non-hex byte gives nibble 0
  // with the bad flag set.
  function automatic hex_t hex_decode(input logic [ByteW-1:0] b);
    hex_t h;
    h.bad    = 1'b0;
    h.nibble = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.nibble = NibbleW'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.nibble = NibbleW'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.nibble = NibbleW'(b - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

[src/dpdc_core.sv]
`timescale 1ns / 1ps

module dpdc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic [dpdc_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [dpdc_pkg::CountW-1:0]   max_payload_i,
  output logic                          res_valid_o,
  output dpdc_pkg::result_t             res_o
);
  import dpdc_pkg::*;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhPayload = 2'd1,
    PhDigit1  = 2'd2,
    PhDigit2  = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    sum_q, sum_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [NibbleW-1:0]  high_q, high_d;
  logic                bad_q, bad_d;
  hex_t                hex;
  logic [ByteW-1:0]    rx_sum;

  assign hex    = hex_decode(rx_byte_i);
  assign rx_sum = {high_q, hex.nibble};

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    count_d     = count_q;
    high_d      = high_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o.kind           = KindPayload;
    res_o.data_byte      = '0;
    res_o.payload_length = count_q;
    res_o.computed_sum   = sum_q;
    res_o.received_sum   = '0;
    case (phase_q)
      PhHunt: begin
        if (rx_byte_i == ChStart) begin
          phase_d = PhPayload;
          sum_d   = '0;
          count_d = '0;
        end
      end
      PhPayload: begin
        if (rx_byte_i == ChStart) begin
          res_valid_o = 1'b1;
          res_o.kind  = KindAbort;
          sum_d       = '0;
          count_d     = '0;
        end else if (rx_byte_i == ChEnd) begin
          phase_d = PhDigit1;
        end else if (count_q < max_payload_i) begin
          count_d              = count_q + 1'b1;
          sum_d                = sum_q + rx_byte_i;
          res_valid_o          = 1'b1;
          res_o.data_byte      = rx_byte_i;
          res_o.payload_length = count_d;
          res_o.computed_sum   = sum_d;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = KindOverflow;
          phase_d     = PhHunt;
        end
      end
      PhDigit1: begin
        bad_d   = hex.bad;
        high_d  = hex.nibble;
        phase_d = PhDigit2;
      end
      default: begin
        res_valid_o        = 1'b1;
        res_o.received_sum = rx_sum;
        if (!bad_q && !hex.bad && rx_sum == sum_q) begin
          res_o.kind      = KindGood;
          res_o.data_byte = ChAck;
        end else begin
          res_o.kind      = KindMismatch;
          res_o.data_byte = ChNak;
        end
        bad_d   = bad_q | hex.bad;
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q   <= '0;
      count_q <= '0;
      high_q  <= '0;
      bad_q   <= 1'b0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      high_q  <= high_d;
      bad_q   <= bad_d;
    end
  end

endmodule

[src/debug_packet_deframer_checksum_unit.sv]
`timescale 1ns / 1ps

// A result beat is loaded into the output register when the byte that causes it
// is accepted, or parked in the skid stage while the master side stalls; bytes
// that cause no result simply update state. Throughput: one byte per cycle,
// set by the state update feeding the result register, with a skid stage so
// the slave side keeps taking beats while the master side stalls until a
// second result is waiting. Reset is asynchronous and active low: the block
// hunts for a start mark and the payload limit returns to 4095.
module debug_packet_deframer_checksum_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: tdata[7:0] rx_byte.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Result stream: tdata[7:0] data_byte, [19:8] payload_length,
  // [27:20] computed_sum, [35:28] received_sum, [39:36] zero.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,
  // Result stream: tuser[2:0] kind.
  output logic [2:0]  m_axis_tuser_o,
  // Register port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import dpdc_pkg::*;

  localparam logic [2:0] AddrMaxPayload = 3'd0;

  logic [CountW-1:0] max_payload_q;
  logic              in_fire;
  logic              res_valid;
  result_t           res;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  result_t           out_q, skid_q;
  logic              out_ready;
  logic              load_out, load_skid;

  // Register port: writes land in the access phase, reads are combinational.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == AddrMaxPayload) ? {20'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o
                 && paddr_i == AddrMaxPayload) begin
      max_payload_q <= pwdata_i[CountW-1:0];
    end
  end

  // The slave side is refused only once the skid stage holds a result, so
  // the ready path never depends combinationally on the master side.
  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  dpdc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .rx_byte_i     (s_axis_tdata_i),
    .max_payload_i (max_payload_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output register with a skid stage behind it. When the output register
  // frees up, a parked result moves forward first; a fresh result can only
  // arrive while the skid stage is empty.
  assign out_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_fire && res_valid) begin
        out_valid_d = 1'b1;
        load_out    = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && skid_valid_q) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {4'd0, out_q.received_sum, out_q.computed_sum,
                            out_q.payload_length, out_q.data_byte};

  // A parked result never sits behind an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // A good packet carries the ack character and matching sums.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KindGood) |->
      (m_axis_tdata_o[7:0] == ChAck && m_axis_tdata_o[27:20] == m_axis_tdata_o[35:28]))
    else $error("good packet reported with wrong ack or unequal sums");

  // A payload beat always counts itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KindPayload) |-> m_axis_tdata_o[19:8] != 12'd0)
    else $error("payload beat reported with zero length");

  // A result leaving the core while both stages are full would be lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid) |=> out_valid_q)
    else $error("accepted result did not reach the output register");

endmodule

[verif/tb_debug_packet_deframer_checksum_unit.sv]
`timescale 1ns / 1ps

module tb_debug_packet_deframer_checksum_unit;
  import dpdc_pkg::*;

  // No beat on either stream and no register access for this many cycles
  // means the block has hung. The longest legal quiet stretch is the long
  // receiver hold-off, which is far shorter.
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned MaxReported = 40;
  localparam int unsigned MaxIdle     = 10;

  // Register map: max_payload is register 0; address 4 decodes to nothing.
  localparam logic [2:0] AddrMaxPayload = 3'd0;
  localparam logic [2:0] AddrUnused     = 3'd4;

  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'

  // Where the deframer is within a packet.
  typedef enum logic [1:0] {
    FrHunt,
    FrPayload,
    FrDigitHi,
    FrDigitLo
  } framer_phase_e;

  // How a generated packet is closed.
  typedef enum int {
    TailGood,
    TailWrong,
    TailJunk,
    TailCut
  } tail_e;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data  = '0;

  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [39:0] res_data;
  logic [2:0]  res_kind;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  debug_packet_deframer_checksum_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tuser_o  (res_kind),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Shadow of the deframer. It is advanced once for every byte that the block
  // accepts, and every result it predicts is queued until the block delivers
  // the matching beat.
  // -------------------------------------------------------------------------
  framer_phase_e fr_phase = FrHunt;
  logic [7:0]    fr_sum   = '0;
  logic [11:0]   fr_count = '0;
  logic [3:0]    fr_high  = '0;
  logic          fr_bad   = 1'b0;
  logic [11:0]   fr_limit = MaxPayloadReset;

  result_t       expected_results[$];

  // Bytes waiting to be offered on the input stream.
  logic [7:0]    tx_bytes[$];

  int unsigned   error_count    = 0;
  int unsigned   bytes_queued   = 0;
  int unsigned   bytes_accepted = 0;
  int unsigned   results_seen   = 0;
  int unsigned   limit_settings = 0;
  int unsigned   kind_seen[5]   = '{default: 0};

  // Idle control, set per phase by the stimulus process.
  bit            src_idle    = 1'b1;
  bit            snk_idle    = 1'b1;
  int unsigned   hold_req    = 0;
  int unsigned   hold_served = 0;

  int unsigned   src_gap   = 0;
  int unsigned   snk_gap   = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet     = 0;

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // Bit 4 set means the byte is not a hex digit; the nibble is then zero.
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    if (b >= CharZero && b <= CharZero + 8'd9) begin
      return {1'b0, 4'(b - CharZero)};
    end
    if (b >= CharLowerA && b <= CharLowerA + 8'd5) begin
      return {1'b0, 4'(b - CharLowerA + 8'd10)};
    end
    if (b >= CharUpperA && b <= CharUpperA + 8'd5) begin
      return {1'b0, 4'(b - CharUpperA + 8'd10)};
    end
    return 5'b1_0000;
  endfunction

  task automatic advance_framer(input logic [7:0] b);
    logic [4:0] dv;
    logic [7:0] rx_sum;
    result_t    r;
    r = '0;
    case (fr_phase)
      FrHunt: begin
        if (b == ChStart) begin
          fr_phase = FrPayload;
          fr_count = '0;
          fr_sum   = '0;
        end
      end
      FrPayload: begin
        if (b == ChStart) begin
          // A fresh start mark aborts the open packet and restarts it.
          r.kind           = KindAbort;
          r.payload_length = fr_count;
          r.computed_sum   = fr_sum;
          expected_results.push_back(r);
          fr_count = '0;
          fr_sum   = '0;
        end else if (b == ChEnd) begin
          fr_phase = FrDigitHi;
        end else if (fr_count < fr_limit) begin
          fr_count         = fr_count + 12'd1;
          fr_sum           = fr_sum + b;
          r.kind           = KindPayload;
          r.data_byte      = b;
          r.payload_length = fr_count;
          r.computed_sum   = fr_sum;
          expected_results.push_back(r);
        end else begin
          // Over the limit: the byte is dropped and hunting resumes.
          r.kind           = KindOverflow;
          r.payload_length = fr_count;
          r.computed_sum   = fr_sum;
          expected_results.push_back(r);
          fr_phase = FrHunt;
        end
      end
      FrDigitHi: begin
        dv       = digit_value(b);
        fr_bad   = dv[4];
        fr_high  = dv[3:0];
        fr_phase = FrDigitLo;
      end
      default: begin
        dv = digit_value(b);
        if (dv[4]) begin
          fr_bad = 1'b1;
        end
        rx_sum = {fr_high, dv[3:0]};
        if (!fr_bad && rx_sum == fr_sum) begin
          r.kind      = KindGood;
          r.data_byte = ChAck;
        end else begin
          r.kind      = KindMismatch;
          r.data_byte = ChNak;
        end
        r.payload_length = fr_count;
        r.computed_sum   = fr_sum;
        r.received_sum   = rx_sum;
        expected_results.push_back(r);
        fr_phase = FrHunt;
      end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Input driver. A new byte is presented once the previous one has been
  // taken and its idle gap has run out; tvalid is assigned once per edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_framer(in_data);
        bytes_accepted++;
        src_gap = src_idle ? $urandom_range(0, MaxIdle) : 0;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor. Every beat taken is checked field by field against the
  // oldest prediction. tready follows a random stall after each beat when sink
  // idling is on, or a long hold-off when the stimulus asks for one, so that
  // the block fills up and has to push back on its input.
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_error($sformatf("result %0d: %s is %0d, expected %0d",
                           results_seen, name, got, want));
    end
  endtask

  task automatic check_result();
    result_t want;
    if (res_data[39:36] != '0) begin
      flag_error($sformatf("result %0d: tdata padding is not zero", results_seen));
    end
    if (expected_results.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_results.pop_front();
      check_field("kind", res_kind, want.kind);
      check_field("data_byte", res_data[7:0], want.data_byte);
      check_field("payload_length", res_data[19:8], want.payload_length);
      check_field("computed_sum", res_data[27:20], want.computed_sum);
      check_field("received_sum", res_data[35:28], want.received_sum);
      kind_seen[want.kind]++;
    end
    results_seen++;
  endtask

  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        check_result();
        snk_gap = snk_idle ? $urandom_range(0, MaxIdle) : 0;
      end
      if (hold_req != hold_served) begin
        hold_left = LongHold;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // The watchdog restarts its count on any beat or register access.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready) ||
        (psel && penable && pready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= StallLimit) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               quiet, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Register port and stimulus helpers.
  // -------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_limit_readback();
    logic [31:0] rd;
    apb_access(1'b0, AddrMaxPayload, '0, rd);
    if (rd != {20'd0, fr_limit}) begin
      flag_error($sformatf("max_payload reads %0d, expected %0d", rd, fr_limit));
    end
  endtask

  // The upper word bits are don't-care for a 12-bit register.
  task automatic set_limit(input logic [31:0] word);
    logic [31:0] rd;
    apb_access(1'b1, AddrMaxPayload, word, rd);
    fr_limit = word[11:0];
    limit_settings++;
    check_limit_readback();
  endtask

  task automatic send(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) begin
      return CharZero + 8'(nib);
    end
    return (upper ? CharUpperA : CharLowerA) + 8'(nib) - 8'd10;
  endfunction

  // A payload byte that is neither framing mark.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChStart || b == ChEnd);
    return b;
  endfunction

  // A start mark, a payload (now and then restarted by a stray start mark)
  // and a trailer that may be right, wrong, carry a non-hex digit or be
  // missing altogether.
  task automatic queue_packet(input int unsigned len);
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    int unsigned pick;
    tail_e tail;
    sum = '0;
    send(ChStart);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        b   = ChStart;
        sum = '0;
      end else begin
        b   = plain_byte();
        sum = sum + b;
      end
      send(b);
    end
    pick = $urandom_range(0, 9);
    tail = (pick < 7) ? TailGood : (pick == 7) ? TailWrong :
           (pick == 8) ? TailJunk : TailCut;
    if (tail == TailCut) begin
      return;
    end
    if (tail == TailWrong) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    hi_c = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
    lo_c = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
    if (tail == TailJunk) begin
      if ($urandom_range(0, 1)) begin
        hi_c = 8'($urandom_range(0, 255));
      end else begin
        lo_c = 8'($urandom_range(0, 255));
      end
    end
    send(ChEnd);
    send(hi_c);
    send(lo_c);
  endtask

  // Mostly well-formed packets of short length, with line noise between them.
  task automatic queue_random(input int unsigned n);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 9) == 0) begin
        queue_packet($urandom_range(13, 40));
      end else begin
        queue_packet($urandom_range(0, 12));
      end
    end
  endtask

  // Waits until every queued byte has been accepted and every result
  // delivered before the next step.
  task automatic drain();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] word, input int unsigned n,
                           input bit src_on, input bit snk_on, input bit hold);
    set_limit(word);
    src_idle = src_on;
    snk_idle = snk_on;
    if (hold) begin
      hold_req++;
    end
    queue_random(n);
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Stimulus: directed corner cases first, then random phases under several
  // payload limits and idle patterns, and one packet that fills its limit.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] word;
    logic [31:0] rd;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The limit must come out of reset at its maximum.
    check_limit_readback();

    // Bytes outside a packet are ignored; the payload extremes sum to FF and
    // the checksum is given in mixed case.
    send(8'h00);
    send(8'hFF);
    send(ChStart);
    send(8'h00);
    send(8'hFF);
    send_text("#Ff");
    // A start mark inside the payload aborts, then a wrong checksum.
    send_text("$A$x#00");
    // Framing marks in the digit positions are taken as bad digits.
    send_text("$#$#");
    // An empty payload with a zero checksum is good.
    send_text("$#00");
    drain();

    // Limit of one: the second byte overflows; a bad low digit mismatches.
    set_limit(32'd1);
    send_text("$ab$#0G");
    drain();

    // Limit of zero: the very first payload byte overflows.
    set_limit(32'd0);
    send_text("$z#00");
    drain();

    // A write to an unmapped register must leave the limit alone.
    apb_access(1'b1, AddrUnused, $urandom(), rd);
    check_limit_readback();

    // Random phases. The first writes junk into the unused upper bits.
    word       = $urandom();
    word[11:0] = 12'd4095;
    run_phase(word, 220, 1'b1, 1'b1, 1'b0);
    run_phase(32'd8, 220, 1'b0, 1'b1, 1'b0);
    run_phase($urandom_range(1, 30), 220, 1'b1, 1'b0, 1'b0);
    // Back-to-back input against a long receiver hold-off.
    run_phase(32'd4095, 220, 1'b0, 1'b0, 1'b1);
    run_phase(32'd0, 60, 1'b1, 1'b1, 1'b0);

    // One packet that fills a limit of 100 bytes, followed by a byte that
    // overflows with the count at the limit.
    set_limit(32'd100);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send(ChStart);
    repeat (101) send(plain_byte());
    drain();

    run_phase($urandom_range(1, 4094), 150, 1'b1, 1'b1, 1'b0);

    $display("Covered %0d input beats and %0d result beats under %0d limit settings.",
             bytes_accepted, results_seen, limit_settings);
    $display("Results: %0d payload, %0d good, %0d mismatch, %0d overflow, %0d abort.",
             kind_seen[KindPayload], kind_seen[KindGood], kind_seen[KindMismatch],
             kind_seen[KindOverflow], kind_seen[KindAbort]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dpdc_pkg.sv
src/dpdc_core.sv
src/debug_packet_deframer_checksum_unit.sv
verif/tb_debug_packet_deframer_checksum_unit.sv
